// File: design/rsrs_pkg.sv
// Shared constants, command codes and controller/datapath interface types for the row store.
`timescale 1ns / 1ps

package rsrs_pkg;

  // Fixed field widths of the command and result ports
  localparam int KEY_W    = 32;
  localparam int ROW_ID_W = 6;
  localparam int COUNT_W  = 7;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SELECT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the command operands
    logic ins_free;    // insert at the popped row id
    logic ins_fresh;   // insert at the high-water row
    logic ins_full;    // report a refused insert
    logic scan_clear;  // reset scan index, pending match and count
    logic scan_step;   // issue a row read and advance the scan index
    logic finish;      // emit the closing result of a range command
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic free_nonempty;
    logic fresh_avail;
    logic hw_zero;
    logic scan_last;
  } stat_t;

endpackage

// File: design/rsrs_ctrl.sv
// Command sequencer for the row store: dispatches inserts and steps range scans.
`timescale 1ns / 1ps

module rsrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        cmd,
  input  rsrs_pkg::stat_t   stat,
  output logic              busy,
  output rsrs_pkg::ctrl_t   ctrl
);
  import rsrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_FREE,
    S_INS_FRESH,
    S_INS_FULL,
    S_SCAN,
    S_SCAN_END,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          case (cmd)
            CMD_INSERT: begin
              if (stat.free_nonempty) begin
                state_next = S_INS_FREE;
              end else if (stat.fresh_avail) begin
                state_next = S_INS_FRESH;
              end else begin
                state_next = S_INS_FULL;
              end
            end
            CMD_SELECT, CMD_DELETE: begin
              ctrl.scan_clear = 1'b1;
              state_next      = stat.hw_zero ? S_FINISH : S_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS_FREE: begin
        ctrl.ins_free = 1'b1;
        state_next    = S_IDLE;
      end
      S_INS_FRESH: begin
        ctrl.ins_fresh = 1'b1;
        state_next     = S_IDLE;
      end
      S_INS_FULL: begin
        ctrl.ins_full = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      // last row read is being evaluated
      S_SCAN_END: state_next = S_FINISH;
      S_FINISH: begin
        ctrl.finish = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: design/rsrs_datapath.sv
// Row store datapath: key, dead mark and free list memories, scan compare and result registers.
`timescale 1ns / 1ps

module rsrs_datapath #(
  parameter int ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rsrs_pkg::ctrl_t                     ctrl,
  input  logic [1:0]                          cmd,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   key,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   range_low,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   range_high,
  output rsrs_pkg::stat_t                     stat,
  output logic                                strobe,
  output logic [rsrs_pkg::ROW_ID_W-1:0]       row_id,
  output logic                                matched,
  output logic [rsrs_pkg::COUNT_W-1:0]        deleted_count,
  output logic                                full_error,
  output logic                                last
);
  import rsrs_pkg::*;

  localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(ROWS + 1);
  localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

  // Memories
  logic signed [KEY_W-1:0] key_mem  [ROWS];
  logic                    dead_mem [ROWS];
  logic [IDX_W-1:0]        free_mem [ROWS];

  // Table counters
  logic [CNT_W-1:0] high_water;
  logic [CNT_W-1:0] free_top;
  logic [CNT_W-1:0] free_top_dec;

  // Captured operands
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] low_q;
  logic signed [KEY_W-1:0] high_q;
  logic                    is_delete;

  // Scan state
  logic [CNT_W-1:0] scan_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_id;
  logic signed [KEY_W-1:0] key_rd;
  logic             dead_rd;
  logic [IDX_W-1:0] free_rd;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_id;
  logic [CNT_W-1:0] del_cnt;

  // Write port controls
  logic             hit;
  logic             del_hit;
  logic             ins_any;
  logic [IDX_W-1:0] ins_id;
  logic             dead_we;
  logic [IDX_W-1:0] dead_wa;
  logic             free_we;

  assign free_top_dec = free_top - CNT_W'(1);

  // Status toward the controller
  assign stat.free_nonempty = (free_top != '0);
  assign stat.fresh_avail   = (high_water != ROWS_C);
  assign stat.hw_zero       = (high_water == '0);
  assign stat.scan_last     = ((scan_idx + CNT_W'(1)) == high_water);

  // Range test on the row read in the previous cycle
  assign hit     = rd_valid && !dead_rd && (key_rd >= low_q) && (key_rd <= high_q);
  assign del_hit = hit && is_delete;

  // Write address and enable selection
  assign ins_any = ctrl.ins_free || ctrl.ins_fresh;
  assign ins_id  = ctrl.ins_free ? free_rd : high_water[IDX_W-1:0];
  assign dead_we = ins_any || del_hit;
  assign dead_wa = ins_any ? ins_id : rd_id;
  assign free_we = del_hit && (free_top != ROWS_C);

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ins_any) begin
      key_mem[ins_id] <= key_q;
    end
    if (dead_we) begin
      dead_mem[dead_wa] <= !ins_any;
    end
    if (free_we) begin
      free_mem[free_top[IDX_W-1:0]] <= rd_id;
    end
    key_rd  <= key_mem[scan_idx[IDX_W-1:0]];
    dead_rd <= dead_mem[scan_idx[IDX_W-1:0]];
    free_rd <= free_mem[free_top_dec[IDX_W-1:0]];
  end

  // Operand capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_q     <= key;
      low_q     <= range_low;
      high_q    <= range_high;
      is_delete <= (cmd == CMD_DELETE);
    end
    if (ctrl.scan_clear) begin
      scan_idx <= '0;
      del_cnt  <= '0;
    end else if (ctrl.scan_step) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (del_hit) begin
      del_cnt <= del_cnt + CNT_W'(1);
    end
    rd_id <= scan_idx[IDX_W-1:0];
    if (hit && !is_delete) begin
      pend_id <= rd_id;
    end
  end

  // Control registers: counters, read pipeline, pending match
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
      free_top   <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.scan_step;
      if (ctrl.ins_fresh) begin
        high_water <= high_water + CNT_W'(1);
      end
      if (ctrl.ins_free) begin
        free_top <= free_top_dec;
      end else if (free_we) begin
        free_top <= free_top + CNT_W'(1);
      end
      if (ctrl.scan_clear) begin
        pend_valid <= 1'b0;
      end else if (hit && !is_delete) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Result registers: one transfer per strobe cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ins_any) begin
        strobe        <= 1'b1;
        row_id        <= ROW_ID_W'(ins_id);
        matched       <= 1'b1;
        deleted_count <= '0;
        full_error    <= 1'b0;
        last          <= 1'b1;
      end else if (ctrl.ins_full) begin
        strobe        <= 1'b1;
        row_id        <= '0;
        matched       <= 1'b0;
        deleted_count <= '0;
        full_error    <= 1'b1;
        last          <= 1'b1;
      end else if (hit && !is_delete && pend_valid) begin
        // a newer match shows the held one is not the final result
        strobe        <= 1'b1;
        row_id        <= ROW_ID_W'(pend_id);
        matched       <= 1'b1;
        deleted_count <= '0;
        full_error    <= 1'b0;
        last          <= 1'b0;
      end else if (ctrl.finish) begin
        strobe        <= 1'b1;
        row_id        <= (!is_delete && pend_valid) ? ROW_ID_W'(pend_id) : '0;
        matched       <= !is_delete && pend_valid;
        deleted_count <= is_delete ? COUNT_W'(del_cnt) : '0;
        full_error    <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

endmodule

// File: design/row_store_range_scan_core.sv
// Top level of the row store with range select and range delete.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low; cmd, key, range_low and range_high are sampled there. Results leave
// on row_id, matched, deleted_count, full_error and last, each valid for the
// single cycle in which strobe is high; the receiver cannot stall, so every
// strobe cycle is a transfer. last marks the final result of a command.
// Insert gives one result. Select and delete scan rows 0 .. high_water-1
// one row per cycle through the key memory read port. The result of an
// insert and the closing result of a scan come in the first cycle with
// busy low, when the next command may already be transferred. Each select
// match is held until the next one is found, the final one comes at the end.
// Command code 3 is dropped without a result. Reset (rst, synchronous)
// empties the table and free list; no clearing pass is needed.
`timescale 1ns / 1ps

module row_store_range_scan_core #(
  parameter int ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   key,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   range_low,
  input  logic signed [rsrs_pkg::KEY_W-1:0]   range_high,
  output logic                                strobe,
  output logic [rsrs_pkg::ROW_ID_W-1:0]       row_id,
  output logic                                matched,
  output logic [rsrs_pkg::COUNT_W-1:0]        deleted_count,
  output logic                                full_error,
  output logic                                last
);
  import rsrs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  rsrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Storage, compare and result registers
  rsrs_datapath #(
    .ROWS (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (cmd),
    .key           (key),
    .range_low     (range_low),
    .range_high    (range_high),
    .stat          (stat),
    .strobe        (strobe),
    .row_id        (row_id),
    .matched       (matched),
    .deleted_count (deleted_count),
    .full_error    (full_error),
    .last          (last)
  );

endmodule
